// ===== design/table_linear_interpolator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Table interpolator assertion macros
// Shared concurrent assertion forms for the checker of the interpolator.
// ----------------------------------------------------------------------------
`ifndef TABLE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLI_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Property checked at every edge, reset included.
`define TLI_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// Table interpolator package
// Status codes, fixed widths and the divider status type.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int TARGET_BITS = 24;
  localparam int STATUS_BITS = 2;

  localparam logic [STATUS_BITS-1:0] ST_INTERP = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_BELOW  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_ABOVE  = 2'd2;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } tli_div_stat_t;

endpackage

// ===== design/tli_div.sv =====
// ----------------------------------------------------------------------------
// Table interpolator divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tli_div
  import tli_pkg::*;
#(
  parameter int ABSCISSA_BITS = 24,
  parameter int VALUE_BITS    = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [ABSCISSA_BITS+VALUE_BITS-1:0] dividend,
  input  logic [ABSCISSA_BITS-1:0]            divisor,
  output logic [VALUE_BITS-1:0]               quotient,
  output tli_div_stat_t                       stat
);

  localparam int AB    = ABSCISSA_BITS;
  localparam int VB    = VALUE_BITS;
  localparam int CNT_W = $clog2(VB);

  logic [AB-1:0]    rem_r;
  logic [VB-1:0]    sh_r;
  logic [AB-1:0]    div_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [AB:0]      partial;
  logic [AB+1:0]    trial;
  logic             ge;
  logic [AB-1:0]    rem_nxt;

  assign partial = {rem_r, sh_r[VB-1]};
  assign trial   = {1'b0, partial} - {2'b00, div_r};
  assign ge      = ~trial[AB+1];
  assign rem_nxt = ge ? trial[AB-1:0] : partial[AB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(VB - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[AB+VB-1:VB];
      sh_r  <= dividend[VB-1:0];
      div_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[VB-2:0], ge};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign quotient    = sh_r;
  assign stat.done   = done_r;
  assign stat.rem_nz = |rem_r;

endmodule

// ===== design/table_linear_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// Table linear interpolator
// Rows of an ascending (abscissa, value) table arrive as words on the in_
// channel, tlast on the final row; cfg_wr_en/cfg_wr_data set the target.
// A target below the first row, above or equal to the last row gives the end
// value in the cycle after that row is taken. The row that brackets the target
// runs one multiply and a restoring divide, one quotient bit per cycle, so the
// input stays not ready through the S_MUL, S_LOAD and S_DIV states until the
// result is registered. One result word per table goes out on the out_
// channel; later rows are taken and dropped until tlast. The output
// register lets new rows in while a result waits, except that a row able to
// produce a result waits for it. Reset clears the target and the table state.
// ----------------------------------------------------------------------------
module table_linear_interpolator_unit
  import tli_pkg::*;
#(
  parameter int ABSCISSA_BITS = 24,
  parameter int VALUE_BITS    = 32,
  parameter int IN_DATA_W     = ((ABSCISSA_BITS + VALUE_BITS + 7) / 8) * 8,
  parameter int OUT_DATA_W    = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [TARGET_BITS-1:0] cfg_wr_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // row_abscissa, row_value
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // result_value
  output logic [STATUS_BITS-1:0] out_tuser   // result_status
);

  localparam int AB    = ABSCISSA_BITS;
  localparam int VB    = VALUE_BITS;
  localparam int EXT_W = (AB > TARGET_BITS) ? AB : TARGET_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  logic [1:0]             state_r;
  logic [TARGET_BITS-1:0] target_r;
  logic [AB-1:0]          prev_abs_r;
  logic [VB-1:0]          prev_val_r;
  logic                   first_seen_r;
  logic                   answered_r;
  logic [VB-1:0]          base_r;
  logic [VB-1:0]          diff_r;
  logic [AB-1:0]          dx_r;
  logic [AB-1:0]          span_r;
  logic                   neg_r;
  logic [AB+VB-1:0]       prod_r;
  logic                   out_valid_r;
  logic [VB-1:0]          out_value_r;
  logic [STATUS_BITS-1:0] out_status_r;

  logic [EXT_W-1:0]       target_ext;
  logic [AB-1:0]          t_abs;
  logic [AB-1:0]          row_abs;
  logic [VB-1:0]          row_val;
  logic                   in_fire;
  logic                   div_start;
  logic [VB-1:0]          quotient;
  tli_div_stat_t          div_stat;
  logic [VB-1:0]          interp_value;

  assign target_ext = EXT_W'(target_r);
  assign t_abs      = target_ext[AB-1:0];
  assign row_abs    = in_tdata[AB-1:0];
  assign row_val    = in_tdata[AB+VB-1:AB];

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready || answered_r);
  assign in_fire   = in_tvalid && in_tready;
  assign div_start = (state_r == S_LOAD);

  assign interp_value = neg_r ? (base_r - quotient - VB'(div_stat.rem_nz))
                              : (base_r + quotient);

  tli_div #(
    .ABSCISSA_BITS(AB),
    .VALUE_BITS   (VB)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(prod_r),
    .divisor (span_r),
    .quotient(quotient),
    .stat    (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      target_r     <= '0;
      prev_abs_r   <= '0;
      prev_val_r   <= '0;
      first_seen_r <= 1'b0;
      answered_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (answered_r) begin
              // Rows after the answer are dropped.
            end else if (!first_seen_r && (t_abs < row_abs)) begin
              out_valid_r  <= 1'b1;
              out_value_r  <= row_val;
              out_status_r <= ST_BELOW;
              answered_r   <= 1'b1;
            end else if (first_seen_r && (row_abs > t_abs)) begin
              base_r     <= prev_val_r;
              neg_r      <= (row_val < prev_val_r);
              diff_r     <= (row_val < prev_val_r) ? (prev_val_r - row_val)
                                                   : (row_val - prev_val_r);
              dx_r       <= t_abs - prev_abs_r;
              span_r     <= row_abs - prev_abs_r;
              answered_r <= 1'b1;
              state_r    <= S_MUL;
            end else if (in_tlast) begin
              out_valid_r  <= 1'b1;
              out_value_r  <= row_val;
              out_status_r <= (row_abs == t_abs) ? ST_INTERP : ST_ABOVE;
              answered_r   <= 1'b1;
            end else begin
              prev_abs_r   <= row_abs;
              prev_val_r   <= row_val;
              first_seen_r <= 1'b1;
            end
            if (in_tlast) begin
              prev_abs_r   <= '0;
              prev_val_r   <= '0;
              first_seen_r <= 1'b0;
              answered_r   <= 1'b0;
            end
          end
        end
        S_MUL: begin
          prod_r  <= (AB+VB)'(diff_r) * (AB+VB)'(dx_r);
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= interp_value;
            out_status_r <= ST_INTERP;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_value_r);
  assign out_tuser  = out_status_r;

endmodule

// ===== design/tli_checker.sv =====
// ----------------------------------------------------------------------------
// Table interpolator port checker
// Watches the result channel of the interpolator over time.
// ----------------------------------------------------------------------------
`include "table_linear_interpolator_unit_macros.svh"

module tli_checker
  import tli_pkg::*;
#(
  parameter int OUT_DATA_W = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_DATA_W-1:0]  out_tdata,
  input logic [STATUS_BITS-1:0] out_tuser
);

  `TLI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result word changed while stalled")

  `TLI_ASSERT_IMP(a_status_code, clk, rst_n, out_tvalid,
    out_tuser == ST_INTERP || out_tuser == ST_BELOW || out_tuser == ST_ABOVE, "bad status code")

  `TLI_ASSERT_ALWAYS(a_reset_idle, clk, $past(!rst_n) |-> !out_tvalid, "result word after reset")

  `TLI_ASSERT_IMP(a_no_new_result, clk, rst_n, $rose(out_tvalid),
    $past((in_tvalid && in_tready) || !in_tready), "result word without a row or a busy cycle")

endmodule

bind table_linear_interpolator_unit tli_checker #(
  .OUT_DATA_W($bits(out_tdata))
) u_tli_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
